@@ src/cddc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cddc_pkg;

    localparam int CDDC_COUNT_BITS = 16;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = YEAR_W + 13;

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [6:0]         YREM_MAX  = 7'd99;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_START,
        S_CHK_END,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic chk_start;
        logic chk_end;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [6:0] rem;   // y % 100
        logic [1:0] q4;    // (y / 100) % 4
    } t_ydiv;

    function automatic t_ydiv year_div(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [7:0]        q;
        logic [YEAR_W-1:0] qx100;
        t_ydiv             res;
        prod  = PROD_W'(y) * PROD_W'(DIV100_MUL);
        q     = prod[DIV100_SHIFT +: 8];
        qx100 = (YEAR_W'(q) << 6) + (YEAR_W'(q) << 5) + (YEAR_W'(q) << 2);
        res.rem = 7'(y - qx100);
        res.q4  = q[1:0];
        return res;
    endfunction

    function automatic logic is_leap(input logic [1:0] y_lo, input t_ydiv d);
        return ((y_lo == 2'd0) && (d.rem != 7'd0)) || ((d.rem == 7'd0) && (d.q4 == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
            default:   len = DAY_W'(0);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ src/cddc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cddc_ctrl
    import cddc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHK_START;
            end
            S_CHK_START: n_state = S_CHK_END;
            S_CHK_END:   n_state = S_WALK;
            S_WALK: begin
                if (i_sts.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_CHK_START: o_cmd.chk_start = 1'b1;
            S_CHK_END:   o_cmd.chk_end   = 1'b1;
            S_WALK:      o_cmd.step      = !i_sts.done;
            S_DONE:      o_cmd.finish    = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ src/cddc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cddc_dp
    import cddc_pkg::*;
#(
    parameter int COUNT_BITS = CDDC_COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic [DAY_W-1:0]      i_start_day,
    input  wire logic [MONTH_W-1:0]    i_start_month,
    input  wire logic [YEAR_W-1:0]     i_start_year,
    input  wire logic [DAY_W-1:0]      i_end_day,
    input  wire logic [MONTH_W-1:0]    i_end_month,
    input  wire logic [YEAR_W-1:0]     i_end_year,
    input  wire logic                  i_include_end,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [COUNT_BITS-1:0]      o_day_count,
    output logic                       o_saturated,
    output logic                       o_bad_date
);

    logic [DAY_W-1:0]    r_walk_day,   n_walk_day;
    logic [MONTH_W-1:0]  r_walk_month, n_walk_month;
    logic [YEAR_W-1:0]   r_walk_year,  n_walk_year;
    logic [DAY_W-1:0]    r_tgt_day;
    logic [MONTH_W-1:0]  r_tgt_month;
    logic [YEAR_W-1:0]   r_tgt_year;
    logic                r_inc;
    logic [COUNT_BITS:0] r_count;
    t_ydiv               r_ydiv, n_ydiv;
    logic                r_bad;
    logic                r_out_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                r_out_sat;
    logic                r_out_bad;

    logic [YEAR_W-1:0]   chk_year;
    logic [DAY_W-1:0]    chk_day;
    logic [MONTH_W-1:0]  chk_month;
    t_ydiv               chk_div;
    logic [DAY_W-1:0]    chk_len;
    logic                chk_ok;
    logic [DAY_W-1:0]    walk_len;
    logic                walk_lt;
    logic                fin_sat;

    // shared leap/validity check: start date first, end date second
    always_comb begin
        chk_year  = i_cmd.chk_end ? r_tgt_year  : r_walk_year;
        chk_day   = i_cmd.chk_end ? r_tgt_day   : r_walk_day;
        chk_month = i_cmd.chk_end ? r_tgt_month : r_walk_month;
        chk_div   = year_div(chk_year);
        chk_len   = days_in(chk_month, is_leap(chk_year[1:0], chk_div));
        chk_ok    = (chk_day != '0) && (chk_day <= chk_len);
    end

    always_comb begin
        walk_len = days_in(r_walk_month, is_leap(r_walk_year[1:0], r_ydiv));
        walk_lt  = {r_walk_year, r_walk_month, r_walk_day}
                 < {r_tgt_year, r_tgt_month, r_tgt_day};
    end

    // next calendar day
    always_comb begin
        n_walk_day   = r_walk_day + DAY_W'(1);
        n_walk_month = r_walk_month;
        n_walk_year  = r_walk_year;
        n_ydiv       = r_ydiv;
        if (r_walk_day == walk_len) begin
            n_walk_day = DAY_W'(1);
            if (r_walk_month == MONTH_DEC) begin
                n_walk_month = MONTH_JAN;
                n_walk_year  = r_walk_year + YEAR_W'(1);
                if (r_ydiv.rem == YREM_MAX) begin
                    n_ydiv.rem = 7'd0;
                    n_ydiv.q4  = r_ydiv.q4 + 2'd1;
                end else begin
                    n_ydiv.rem = r_ydiv.rem + 7'd1;
                end
            end else begin
                n_walk_month = r_walk_month + MONTH_W'(1);
            end
        end
    end

    always_comb begin
        o_sts.done     = r_bad || !walk_lt || r_count[COUNT_BITS];
        o_sts.out_free = !r_out_valid || i_ready;
        fin_sat        = r_count[COUNT_BITS] || (r_inc && (&r_count[COUNT_BITS-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_walk_day   <= i_start_day;
            r_walk_month <= i_start_month;
            r_walk_year  <= i_start_year;
            r_tgt_day    <= i_end_day;
            r_tgt_month  <= i_end_month;
            r_tgt_year   <= i_end_year;
            r_inc        <= i_include_end;
            r_count      <= '0;
            r_bad        <= 1'b0;
        end else if (i_cmd.chk_start) begin
            r_ydiv <= chk_div;
            r_bad  <= !chk_ok;
        end else if (i_cmd.chk_end) begin
            r_bad  <= r_bad || !chk_ok;
        end else if (i_cmd.step) begin
            r_walk_day   <= n_walk_day;
            r_walk_month <= n_walk_month;
            r_walk_year  <= n_walk_year;
            r_ydiv       <= n_ydiv;
            r_count      <= r_count + (COUNT_BITS+1)'(1);
        end
        if (i_cmd.finish) begin
            r_out_bad <= r_bad;
            if (r_bad) begin
                r_out_count <= '0;
                r_out_sat   <= 1'b0;
            end else if (fin_sat) begin
                r_out_count <= '1;
                r_out_sat   <= 1'b1;
            end else begin
                r_out_count <= r_count[COUNT_BITS-1:0] + COUNT_BITS'(r_inc);
                r_out_sat   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_day_count = r_out_count;
    assign o_saturated = r_out_sat;
    assign o_bad_date  = r_out_bad;

endmodule

`default_nettype wire

@@ src/calendar_day_difference_counter.sv @@
// A result word follows the start-date check, the end-date check and a walk of N days,
//   N capped at 2^COUNT_BITS; bad dates skip the walk.
// Words are taken one at a time; the walk loop steps one day per cycle.
// The result register holds a finished word while the next word is taken.
// Reset (i_rst_n low, synchronous): controller to idle, result register empty.
`timescale 1ns / 1ps
`default_nettype none

module calendar_day_difference_counter
    import cddc_pkg::*;
#(
    parameter int COUNT_BITS = CDDC_COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DAY_W-1:0]      i_start_day,
    input  wire logic [MONTH_W-1:0]    i_start_month,
    input  wire logic [YEAR_W-1:0]     i_start_year,
    input  wire logic [DAY_W-1:0]      i_end_day,
    input  wire logic [MONTH_W-1:0]    i_end_month,
    input  wire logic [YEAR_W-1:0]     i_end_year,
    input  wire logic                  i_include_end,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [COUNT_BITS-1:0]      o_day_count,
    output logic                       o_saturated,
    output logic                       o_bad_date
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    cddc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    cddc_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_end_day     (i_end_day),
        .i_end_month   (i_end_month),
        .i_end_year    (i_end_year),
        .i_include_end (i_include_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_day_count   (o_day_count),
        .o_saturated   (o_saturated),
        .o_bad_date    (o_bad_date)
    );

endmodule

`default_nettype wire

@@ src/cddc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cddc_chk
    import cddc_pkg::*;
#(
    parameter int COUNT_BITS = CDDC_COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  o_ready,
    input  wire logic                  o_valid,
    input  wire logic                  i_ready,
    input  wire logic [COUNT_BITS-1:0] o_day_count,
    input  wire logic                  o_saturated,
    input  wire logic                  o_bad_date
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_day_count)
            && $stable(o_saturated) && $stable(o_bad_date))
        else $error("result word changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_date |-> (o_day_count == '0) && !o_saturated)
        else $error("bad date with nonzero count");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (&o_day_count) && !o_bad_date)
        else $error("saturated word not at maximum");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accepting a word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind calendar_day_difference_counter cddc_chk #(.COUNT_BITS(COUNT_BITS)) u_cddc_chk (.*);

`default_nettype wire
